### hdl/lhr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram recorder package
// Shared widths, request codes and the beat and queue entry types.
// ----------------------------------------------------------------------------
package lhr_pkg;

  // Field widths and sizes.
  localparam int SAMPLE_BITS = 32;
  localparam int NUM_BUCKETS = 64;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int COUNT_W     = 32;
  localparam int TOTAL_W     = 64;
  localparam int USED_W      = BKT_W + 1;
  localparam int REQ_W       = 2;

  // Log-linear bucket layout: leading-one positions below LIN_H are split
  // into 2**SUB_BITS sub-buckets, positions at or above it land in the last bucket.
  localparam int LIN_H    = 16;
  localparam int SUB_BITS = 2;
  localparam int LEAD_W   = $clog2(LIN_H);

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Request codes on the input channel.
  localparam logic [REQ_W-1:0] REQ_RECORD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Saturation and reset values of the statistics.
  localparam logic [COUNT_W-1:0]            COUNT_MAX  = '1;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Operation kind after classification.
  typedef enum logic [1:0] {
    OP_RECORD,
    OP_READ,
    OP_CLEAR
  } op_e;

  // Input beat.
  typedef struct packed {
    logic [REQ_W-1:0]              req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [BKT_W-1:0]              read_index;
  } req_t;

  // Output beat.
  typedef struct packed {
    logic [COUNT_W-1:0]            sample_count;
    logic signed [TOTAL_W-1:0]     sample_total;
    logic signed [SAMPLE_BITS-1:0] sample_min;
    logic signed [SAMPLE_BITS-1:0] sample_max;
    logic [BKT_W-1:0]              sample_bucket;
    logic [COUNT_W-1:0]            bucket_value;
    logic [USED_W-1:0]             used_buckets;
  } rsp_t;

  // Classified operation handed from front to back.
  typedef struct packed {
    op_e                           kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [BKT_W-1:0]              read_index;
    logic [BKT_W-1:0]              bucket;
  } op_t;

endpackage

### hdl/lhr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram recorder front end
// Decodes the request kind and computes the log-linear bucket of the sample.
// ----------------------------------------------------------------------------
module lhr_front (
  input  lhr_pkg::req_t req_i,
  output lhr_pkg::op_t  op_o
);
  import lhr_pkg::*;

  // Bucket of a sample: non-positive values go to bucket 0, large values to
  // the last bucket, otherwise the leading-one position and two bits below.
  function automatic logic [BKT_W-1:0] pick_bucket(input logic signed [SAMPLE_BITS-1:0] s);
    logic [LEAD_W-1:0]         h;
    logic [LIN_H+SUB_BITS-1:0] w;
    logic                      big;
    h   = '0;
    w   = {s[LIN_H-1:0], {SUB_BITS{1'b0}}};
    big = |s[SAMPLE_BITS-2:LIN_H];
    for (int i = 0; i < LIN_H; i++) begin
      if (s[i]) begin
        h = LEAD_W'(i);
      end
    end
    if (s[SAMPLE_BITS-1] || (s == '0)) begin
      return '0;
    end
    if (big) begin
      return BKT_W'(NUM_BUCKETS - 1);
    end
    return {h, w[h +: SUB_BITS]};
  endfunction

  // Request decode; the unused code behaves as a read.
  always_comb begin
    op_o.sample     = req_i.sample;
    op_o.read_index = req_i.read_index;
    op_o.bucket     = pick_bucket(req_i.sample);
    unique case (req_i.req_type)
      REQ_RECORD: op_o.kind = OP_RECORD;
      REQ_CLEAR:  op_o.kind = OP_CLEAR;
      default:    op_o.kind = OP_READ;
    endcase
  end

endmodule

### hdl/lhr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram recorder operation queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lhr_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lhr_pkg::op_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output lhr_pkg::op_t pop_data_o,
  output logic         empty_o
);
  import lhr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = store_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/lhr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram recorder back end
// Bucket memory with read-modify-write, running statistics and output register.
// ----------------------------------------------------------------------------
module lhr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lhr_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          op_pop_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output lhr_pkg::rsp_t rsp_o
);
  import lhr_pkg::*;

  // Bucket memory and per-entry valid bits; an invalid entry reads as zero.
  logic [COUNT_W-1:0]     mem_q [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] vld_q;
  logic [COUNT_W-1:0]     rd_bkt_q, rd_idx_q;

  // Last write, forwarded to the operation that read in the same cycle.
  logic [BKT_W-1:0]   wr_addr_q;
  logic [COUNT_W-1:0] wr_data_q;

  // Execute stage.
  op_t  y_op_q;
  logic y_valid_q;
  logic y_adv;

  // Statistics.
  logic [COUNT_W-1:0]            count_q, count_d;
  logic signed [TOTAL_W-1:0]     total_q, total_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [USED_W-1:0]             used_q, used_d;

  // Output register.
  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q;

  logic               is_rec, is_clr;
  logic [BKT_W-1:0]   bkt, ridx;
  logic [COUNT_W-1:0] old_cnt, new_cnt, rd_cnt;
  logic [USED_W-1:0]  bkt_len;

  // Stage handshake: execute moves on when the output register frees up.
  assign y_adv       = y_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign op_pop_o    = op_valid_i && (!y_valid_q || y_adv);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Memory: two registered reads when an operation enters, one write on record.
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      rd_bkt_q <= mem_q[op_i.bucket];
      rd_idx_q <= mem_q[op_i.read_index];
    end
    if (y_adv && is_rec) begin
      mem_q[bkt] <= new_cnt;
    end
  end

  // Payload registers of the execute stage and the write bypass.
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      y_op_q <= op_i;
    end
    if (y_adv && is_rec) begin
      wr_addr_q <= bkt;
      wr_data_q <= new_cnt;
    end
    if (y_adv) begin
      rsp_q <= rsp_d;
    end
  end

  // Bucket counts and next statistics for the operation in execute.
  always_comb begin
    is_rec  = (y_op_q.kind == OP_RECORD);
    is_clr  = (y_op_q.kind == OP_CLEAR);
    bkt     = y_op_q.bucket;
    ridx    = y_op_q.read_index;
    bkt_len = USED_W'(bkt) + USED_W'(1);

    if (!vld_q[bkt]) begin
      old_cnt = '0;
    end else if (wr_addr_q == bkt) begin
      old_cnt = wr_data_q;
    end else begin
      old_cnt = rd_bkt_q;
    end
    new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_W'(1);

    if (!vld_q[ridx]) begin
      rd_cnt = '0;
    end else if (wr_addr_q == ridx) begin
      rd_cnt = wr_data_q;
    end else begin
      rd_cnt = rd_idx_q;
    end

    count_d = count_q;
    total_d = total_q;
    min_d   = min_q;
    max_d   = max_q;
    used_d  = used_q;
    if (is_clr) begin
      count_d = '0;
      total_d = '0;
      min_d   = SAMPLE_POS;
      max_d   = SAMPLE_NEG;
      used_d  = '0;
    end else if (is_rec) begin
      if (count_q != COUNT_MAX) begin
        count_d = count_q + COUNT_W'(1);
      end
      total_d = total_q + {{(TOTAL_W-SAMPLE_BITS){y_op_q.sample[SAMPLE_BITS-1]}},
                           y_op_q.sample};
      if (y_op_q.sample < min_q) begin
        min_d = y_op_q.sample;
      end
      if (y_op_q.sample > max_q) begin
        max_d = y_op_q.sample;
      end
      if (bkt_len > used_q) begin
        used_d = bkt_len;
      end
    end

    rsp_d.sample_count  = count_d;
    rsp_d.sample_total  = total_d;
    rsp_d.sample_min    = (count_d != '0) ? min_d : '0;
    rsp_d.sample_max    = (count_d != '0) ? max_d : '0;
    rsp_d.sample_bucket = is_rec ? bkt : '0;
    rsp_d.used_buckets  = used_d;
    if (is_clr) begin
      rsp_d.bucket_value = '0;
    end else if (is_rec && (ridx == bkt)) begin
      rsp_d.bucket_value = new_cnt;
    end else begin
      rsp_d.bucket_value = rd_cnt;
    end
  end

  // Control state, valid bits and statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_valid_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      vld_q       <= '0;
      count_q     <= '0;
      total_q     <= '0;
      min_q       <= SAMPLE_POS;
      max_q       <= SAMPLE_NEG;
      used_q      <= '0;
    end else begin
      if (op_pop_o) begin
        y_valid_q <= 1'b1;
      end else if (y_adv) begin
        y_valid_q <= 1'b0;
      end
      if (y_adv) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (y_adv) begin
        count_q <= count_d;
        total_q <= total_d;
        min_q   <= min_d;
        max_q   <= max_d;
        used_q  <= used_d;
        if (is_clr) begin
          vld_q <= '0;
        end else if (is_rec) begin
          vld_q[bkt] <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/latency_histogram_recorder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram recorder core
// Count, total, min, max and a 64-bucket log-linear histogram of samples.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Beat
//  req     | in        | req_valid_i/req_ready_o | req_t: kind, sample, read index
//  rsp     | out       | rsp_valid_o/rsp_ready_i | rsp_t: statistics and bucket value
//
//  One request per cycle is sustained while rsp_ready_i stays high; each request
//  gives one response beat, through the queue, execute and output registers.
//  The bucket memory update is a read-modify-write with a one-deep bypass,
//  which keeps back-to-back records to the same bucket at full rate.
//  Reset clears the bucket valid bits at once; no clearing pass is needed.
//  A stalled response holds the execute stage; the two-entry queue keeps
//  accepting requests until it is full.
// ----------------------------------------------------------------------------
module latency_histogram_recorder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  lhr_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output lhr_pkg::rsp_t rsp_o
);
  import lhr_pkg::*;

  op_t  front_op, queue_op;
  logic queue_full, queue_empty, queue_pop;
  logic push;

  assign req_ready_o = !queue_full;
  assign push        = req_valid_i && !queue_full;

  // Classification.
  lhr_front u_front (
    .req_i (req_i),
    .op_o  (front_op)
  );

  // Decoupling queue.
  lhr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_op),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_op),
    .empty_o     (queue_empty)
  );

  // Execution.
  lhr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (queue_op),
    .op_valid_i  (!queue_empty),
    .op_pop_o    (queue_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // A nonempty histogram goes with a nonzero sample count.
  a_used_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ((rsp_o.sample_count == '0) == (rsp_o.used_buckets == '0)))
    else $error("used bucket length disagrees with sample count");

  // The bucket just recorded lies within the used length.
  a_bucket_in_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.sample_bucket != '0))
      |-> (USED_W'(rsp_o.sample_bucket) < rsp_o.used_buckets))
    else $error("recorded bucket beyond used length");

  // Minimum never exceeds maximum once samples exist.
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.sample_count != '0)) |-> (rsp_o.sample_min <= rsp_o.sample_max))
    else $error("sample minimum above maximum");

endmodule

### test/lhr_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram statistics checker
// Watches the request and response channels of the recorder core, keeps its
// own copy of the statistics and the histogram, and compares every response
// beat field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module lhr_stats_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  lhr_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  lhr_pkg::rsp_t rsp_i,
  output int            pending_o,
  output int            fail_count_o
);
  import lhr_pkg::*;

  localparam int MAX_REPORTS = 10;

  // Shadow statistics.
  logic [COUNT_W-1:0]            stat_count;
  logic signed [TOTAL_W-1:0]     stat_total;
  logic signed [SAMPLE_BITS-1:0] stat_min;
  logic signed [SAMPLE_BITS-1:0] stat_max;
  logic [COUNT_W-1:0]            hist [NUM_BUCKETS];
  logic [USED_W-1:0]             hist_len;

  rsp_t expected_rsp_q [$];
  int   mismatches = 0;

  // Log-linear bucket of one sample.
  function automatic logic [BKT_W-1:0] bucket_of(input logic signed [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] mag;
    logic [SUB_BITS-1:0]    sub;
    int                     lead;
    if (s <= 0) return '0;
    mag  = s;
    lead = 0;
    for (int b = 0; b < SAMPLE_BITS; b++) begin
      if (mag[b]) lead = b;
    end
    if (lead >= LIN_H) return BKT_W'(NUM_BUCKETS - 1);
    if (lead >= SUB_BITS) begin
      sub = SUB_BITS'(mag >> (lead - SUB_BITS));
    end else begin
      sub = SUB_BITS'(mag << (SUB_BITS - lead));
    end
    return BKT_W'((lead << SUB_BITS) + sub);
  endfunction

  function automatic void clear_stats();
    stat_count = '0;
    stat_total = '0;
    stat_min   = SAMPLE_POS;
    stat_max   = SAMPLE_NEG;
    for (int b = 0; b < NUM_BUCKETS; b++) hist[b] = '0;
    hist_len   = '0;
  endfunction

  // Apply one request beat to the shadow state and return the response it causes.
  function automatic rsp_t apply_request(input req_t rq);
    rsp_t             beat;
    logic [BKT_W-1:0] bkt;
    bkt = '0;
    if (rq.req_type == REQ_RECORD) begin
      if (stat_count != COUNT_MAX) stat_count = stat_count + 1'b1;
      stat_total = stat_total + rq.sample;
      if (rq.sample < stat_min) stat_min = rq.sample;
      if (rq.sample > stat_max) stat_max = rq.sample;
      bkt = bucket_of(rq.sample);
      if (hist[bkt] != COUNT_MAX) hist[bkt] = hist[bkt] + 1'b1;
      if (USED_W'(bkt) + 1'b1 > hist_len) hist_len = USED_W'(bkt) + 1'b1;
    end else if (rq.req_type == REQ_CLEAR) begin
      clear_stats();
    end
    // Any other code, the unused one included, only reads.
    beat.sample_count  = stat_count;
    beat.sample_total  = stat_total;
    beat.sample_min    = (stat_count != '0) ? stat_min : '0;
    beat.sample_max    = (stat_count != '0) ? stat_max : '0;
    beat.sample_bucket = bkt;
    beat.bucket_value  = hist[rq.read_index];
    beat.used_buckets  = hist_len;
    return beat;
  endfunction

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS) begin
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      end
      mismatches++;
    end
  endtask

  // Response beats are retired before the request beat of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      clear_stats();
      expected_rsp_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("response beat with no request waiting: 0x%0h", rsp_i);
          end
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("sample_count",  64'(rsp_i.sample_count),  64'(want.sample_count));
          check_field("sample_total",  64'(rsp_i.sample_total),  64'(want.sample_total));
          check_field("sample_min",    64'(rsp_i.sample_min),    64'(want.sample_min));
          check_field("sample_max",    64'(rsp_i.sample_max),    64'(want.sample_max));
          check_field("sample_bucket", 64'(rsp_i.sample_bucket), 64'(want.sample_bucket));
          check_field("bucket_value",  64'(rsp_i.bucket_value),  64'(want.bucket_value));
          check_field("used_buckets",  64'(rsp_i.used_buckets),  64'(want.used_buckets));
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_rsp_q.push_back(apply_request(req_i));
      end
      pending_o    <= expected_rsp_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### test/tb_latency_histogram_recorder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram recorder core testbench
// Drives directed and random record, read and clear beats with random gaps on
// both channels; a checker beside the core predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_latency_histogram_recorder_core;
  import lhr_pkg::*;

  localparam int NUM_RANDOM = 1800;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i       = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;
  int   pending;
  int   fail_count;
  int   idle_cycles = 0;

  latency_histogram_recorder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  lhr_stats_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_i  (req_ready_o),
    .req_i        (req_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_ready_i  (rsp_ready_i),
    .rsp_i        (rsp_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t make_req(input logic [REQ_W-1:0] kind,
                                    input logic signed [SAMPLE_BITS-1:0] s,
                                    input logic [BKT_W-1:0] idx);
    req_t beat;
    beat.req_type   = kind;
    beat.sample     = s;
    beat.read_index = idx;
    return beat;
  endfunction

  // Random sample spread over all bucket ranges, signs and extremes.
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 16);
    if (r < 60) return $urandom >> $urandom_range(14, 31);
    if (r < 70) return -$signed(32'($urandom_range(1, 1000)));
    if (r < 76) begin
      case ($urandom_range(0, 5))
        0:       return SAMPLE_POS;
        1:       return SAMPLE_NEG;
        2:       return '0;
        3:       return -1;
        4:       return 32'h0000_FFFF;
        default: return 32'h0001_0000;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly records; reads, the spare code and the odd clear mixed in.
  function automatic req_t rand_req();
    int                 r;
    logic [REQ_W-1:0]   kind;
    r = $urandom_range(0, 199);
    if (r < 160)      kind = REQ_RECORD;
    else if (r < 186) kind = REQ_READ;
    else if (r < 196) kind = REQ_SPARE;
    else              kind = REQ_CLEAR;
    return make_req(kind, rand_sample(), BKT_W'($urandom));
  endfunction

  // Present one request beat after an optional gap and hold it until accepted.
  task automatic send_req(input req_t beat, input int gap);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      req_i       <= rand_req();
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= beat;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  // Hold off the request side until every predicted response has arrived.
  task automatic wait_drained();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Response side: random stalls with some long stretches of steady ready.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      rsp_ready_i <= 1'b1;
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(20, 100)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        rsp_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[latency_histogram_recorder_core] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    bit burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty reads, clear on empty, extremes and bucket boundaries.
    send_req(make_req(REQ_READ,   32'sd0, 6'd0),  0);
    send_req(make_req(REQ_READ,   32'sd0, 6'd63), 0);
    send_req(make_req(REQ_CLEAR,  32'sd5, 6'd0),  0);
    send_req(make_req(REQ_RECORD, 32'sd0, 6'd0),  0);
    send_req(make_req(REQ_RECORD, -32'sd1, 6'd0), 1);
    send_req(make_req(REQ_RECORD, SAMPLE_NEG, 6'd0), 0);
    send_req(make_req(REQ_RECORD, SAMPLE_POS, 6'd63), 0);
    send_req(make_req(REQ_RECORD, 32'sd1, 6'd0), 0);
    send_req(make_req(REQ_RECORD, 32'sd2, 6'd4), 2);
    send_req(make_req(REQ_RECORD, 32'sd3, 6'd6), 0);
    send_req(make_req(REQ_RECORD, 32'sd4, 6'd8), 0);
    send_req(make_req(REQ_RECORD, 32'sd7, 6'd11), 0);
    send_req(make_req(REQ_RECORD, 32'sd7, 6'd11), 0);
    send_req(make_req(REQ_RECORD, 32'sh0000_8000, 6'd60), 3);
    send_req(make_req(REQ_RECORD, 32'sh0000_FFFF, 6'd63), 0);
    send_req(make_req(REQ_RECORD, 32'sh0001_0000, 6'd63), 0);
    send_req(make_req(REQ_SPARE,  32'sh7FFF_FFFF, 6'd63), 0);
    send_req(make_req(REQ_READ,   32'sd0, 6'd11), 0);
    send_req(make_req(REQ_CLEAR,  32'sd0, 6'd63), 0);
    send_req(make_req(REQ_READ,   32'sd0, 6'd63), 0);
    send_req(make_req(REQ_RECORD, 32'sd5, 6'd5), 0);
    send_req(make_req(REQ_RECORD, -32'sd100, 6'd0), 0);
    send_req(make_req(REQ_READ,   32'sd0, 6'd5), 0);
    wait_drained();

    // Random phase with burst stretches and occasional full drains.
    burst = 1'b0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i % 600 == 300) wait_drained();
      send_req(rand_req(), burst ? 0 : gap_len());
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("[latency_histogram_recorder_core] OK");
    end else begin
      $display("[latency_histogram_recorder_core] ERROR");
    end
    $finish;
  end

endmodule
